// File: rtl/laplacian_sharpen_stream_unit_assert.svh
// assertion macros shared by the checker of the sharpening stream unit
// expects clk and arst_n to be visible where a macro is used

`ifndef LAPLACIAN_SHARPEN_STREAM_UNIT_ASSERT_SVH
`define LAPLACIAN_SHARPEN_STREAM_UNIT_ASSERT_SVH

// same-cycle implication
`define LSS_ASSERT_IMM(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lss_pkg.sv
// types and constants of the laplacian sharpening stream unit
// used by the top level
`default_nettype none

package lss_pkg;

	typedef enum logic [1:0] {
		REG_AMOUNT       = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} lss_reg_t;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int AMOUNT_W    = 7;
	localparam int FWIDTH_W    = 11;
	localparam int FHEIGHT_W   = 13;
	localparam int ROW_W       = 12;
	localparam int MAX_HEIGHT  = 4096;

	localparam logic [AMOUNT_W-1:0]  AMOUNT_RST  = 7'd50;
	localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 11'd640;
	localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = 13'd480;

	localparam int LAP_W  = 11;
	localparam int MAG_W  = 10;
	localparam int PROD_W = 17;
	localparam int RCP_W  = 18;
	localparam int QW     = PROD_W + RCP_W;
	localparam int Q_W    = 12;
	localparam int V_W    = 14;

	// floor(p/50) == (p * ceil(2^23/50)) >> 23 for p below 2^17
	localparam logic [RCP_W-1:0] RECIP_50    = 18'd167773;
	localparam int               RECIP_SHIFT = 23;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int FIFO_CW    = 4;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       frame_end;
	} lss_result_t;

endpackage

`default_nettype wire

// File: rtl/lss_stream_ifs.sv
// pixel request channels of the sharpening stream unit
// input channel carries drain and argb, output channel carries argb and frame end
`default_nettype none

interface lss_in_if;
	logic       valid;
	logic       ready;
	logic       drain;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;

	modport source (output valid, drain, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, drain, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface lss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	logic       frame_end;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
		output ready);
endinterface

`default_nettype wire

// File: rtl/laplacian_sharpen_stream_unit.sv
// top level of the laplacian sharpening stream unit
// depends on lss_pkg and the request channels in lss_stream_ifs
`default_nettype none

// Takes one ARGB pixel request per clock in raster order and returns the
// 4-neighbour Laplacian sharpened pixel one line plus one pixel later; border
// pixels and everything at amount 0 pass unchanged, alpha always passes.
// After the last pixel of a frame, drain requests push out the pending pixels,
// one per drain. The datapath is a three-stage pipeline (line store read,
// Laplacian, gain multiply, then divide by fifty and clamp) that takes a new
// request every cycle while the queue has room; a result passes the stage 1,
// 2 and 3 registers before it is written into the output queue and can leave
// on the following cycle. The 8-entry output queue decouples the two sides:
// the input stalls only when queued plus in-flight results would overfill it.
// Configuration must be written only while the unit is idle; writes are
// applied at once and are not held off.
module laplacian_sharpen_stream_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [lss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [lss_pkg::CFG_DATA_W-1:0]       cfg_data,
	lss_in_if.sink                              pix_in,
	lss_out_if.source                           pix_out
);

	localparam int CLW = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 2);
	localparam logic [lss_pkg::FHEIGHT_W-1:0] MAXW_X = lss_pkg::FHEIGHT_W'(MAX_WIDTH);
	localparam logic [lss_pkg::FHEIGHT_W-1:0] MAXH_X =
		lss_pkg::FHEIGHT_W'(lss_pkg::MAX_HEIGHT);

	// configuration
	logic [lss_pkg::AMOUNT_W-1:0]  amount_q;
	logic [lss_pkg::FWIDTH_W-1:0]  frame_width_q;
	logic [lss_pkg::FHEIGHT_W-1:0] frame_height_q;

	// position and pending state
	logic [CLW-1:0]           in_col_q, out_col_q;
	logic [lss_pkg::ROW_W-1:0] in_row_q, out_row_q;
	logic [WW-1:0]            pend_q;

	// line stores and window
	logic [31:0] upper_mem [MAX_WIDTH];
	logic [31:0] middle_mem [MAX_WIDTH];
	logic [31:0] win_q [9];

	// stage 1
	logic                     wr_s1, res_s1, sharp_s1, fe_s1, up_s1, byp_s1;
	logic [31:0]              pix_s1, up_rd_s1, mid_rd_s1, byp_up_s1, byp_mid_s1;
	logic [CLW-1:0]           col_s1;

	// stage 2
	logic                              res_s2, sharp_s2, fe_s2;
	logic [31:0]                       cen_s2;
	logic signed [lss_pkg::LAP_W-1:0]  lap_s2 [3];

	// stage 3
	logic                              res_s3, sharp_s3, fe_s3;
	logic [31:0]                       cen_s3;
	logic [lss_pkg::PROD_W-1:0]        prod_s3 [3];
	logic [2:0]                        neg_s3;

	// output queue
	lss_pkg::lss_result_t              fifo_mem [lss_pkg::FIFO_DEPTH];
	logic [lss_pkg::FIFO_AW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [lss_pkg::FIFO_CW-1:0]       cnt_q;

	// control signals
	logic [lss_pkg::FHEIGHT_W-1:0] fw_x, w_x, h_x;
	logic [WW-1:0]                 w, wp1, pend_sat, in_colp1, out_colp1;
	logic [lss_pkg::FHEIGHT_W-1:0] in_rowp1, out_rowp1;
	logic                          acc, is_drain, drain_act, pix_emit, res;
	logic                          interior, fe_now;
	logic [CLW-1:0]                rd_addr;
	logic [lss_pkg::FIFO_CW-1:0]   busy;
	logic                          in_rdy, push, pop;
	logic [31:0]                   pix_word, mid_eff, up_eff, cen_c;
	logic signed [lss_pkg::LAP_W-1:0] lap_c [3];
	logic [lss_pkg::MAG_W-1:0]     mag_c [3];
	logic [lss_pkg::PROD_W-1:0]    prod_c [3];
	logic [7:0]                    ch_out [3];
	lss_pkg::lss_result_t          res_c;

	always_comb begin
		fw_x = lss_pkg::FHEIGHT_W'(frame_width_q);
		if (fw_x == '0) begin
			w_x = lss_pkg::FHEIGHT_W'(1);
		end else if (fw_x > MAXW_X) begin
			w_x = MAXW_X;
		end else begin
			w_x = fw_x;
		end
		if (frame_height_q == '0) begin
			h_x = lss_pkg::FHEIGHT_W'(1);
		end else if (frame_height_q > MAXH_X) begin
			h_x = MAXH_X;
		end else begin
			h_x = frame_height_q;
		end
	end

	assign w         = WW'(w_x);
	assign wp1       = w + WW'(1);
	assign pend_sat  = (pend_q > wp1) ? wp1 : pend_q;
	assign in_colp1  = WW'(in_col_q) + WW'(1);
	assign out_colp1 = WW'(out_col_q) + WW'(1);
	assign in_rowp1  = lss_pkg::FHEIGHT_W'(in_row_q) + lss_pkg::FHEIGHT_W'(1);
	assign out_rowp1 = lss_pkg::FHEIGHT_W'(out_row_q) + lss_pkg::FHEIGHT_W'(1);

	assign busy = cnt_q + lss_pkg::FIFO_CW'(res_s1) + lss_pkg::FIFO_CW'(res_s2)
		+ lss_pkg::FIFO_CW'(res_s3);
	assign in_rdy = busy < lss_pkg::FIFO_CW'(lss_pkg::FIFO_DEPTH);
	assign pix_in.ready = in_rdy;
	assign acc = pix_in.valid && in_rdy;

	assign is_drain  = pix_in.drain;
	assign drain_act = is_drain && (in_col_q == '0) && (in_row_q == '0) && (pend_sat != '0);
	assign pix_emit  = !is_drain && (pend_sat == wp1);
	assign res       = drain_act || pix_emit;
	assign interior  = (amount_q != '0) && (out_row_q != '0) && (out_rowp1 < h_x)
		&& (out_col_q != '0) && (out_colp1 < w);
	assign fe_now    = (out_rowp1 >= h_x) && (out_colp1 >= w);
	assign rd_addr   = is_drain ? out_col_q : in_col_q;
	assign pix_word  = {pix_in.alpha_in, pix_in.red_in, pix_in.green_in, pix_in.blue_in};

	// configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q       <= lss_pkg::AMOUNT_RST;
			frame_width_q  <= lss_pkg::FWIDTH_RST;
			frame_height_q <= lss_pkg::FHEIGHT_RST;
			in_col_q       <= '0;
			in_row_q       <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
			pend_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (lss_pkg::lss_reg_t'(cfg_index))
					lss_pkg::REG_AMOUNT: begin
						amount_q <= cfg_data[lss_pkg::AMOUNT_W-1:0];
					end
					lss_pkg::REG_FRAME_WIDTH: begin
						frame_width_q <= cfg_data[lss_pkg::FWIDTH_W-1:0];
					end
					lss_pkg::REG_FRAME_HEIGHT: begin
						frame_height_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (acc) begin
				if (is_drain) begin
					pend_q <= drain_act ? pend_sat - WW'(1) : pend_sat;
				end else begin
					pend_q <= pix_emit ? pend_sat : pend_sat + WW'(1);
					if (in_colp1 >= w) begin
						in_col_q <= '0;
						in_row_q <= (in_rowp1 >= h_x) ? '0 : lss_pkg::ROW_W'(in_rowp1);
					end else begin
						in_col_q <= CLW'(in_colp1);
					end
				end
				if (res) begin
					if (out_colp1 >= w) begin
						out_col_q <= '0;
						out_row_q <= (out_rowp1 >= h_x) ? '0 : lss_pkg::ROW_W'(out_rowp1);
					end else begin
						out_col_q <= CLW'(out_colp1);
					end
				end
			end
		end
	end

	// pipeline valid flags and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1  <= 1'b0;
			res_s1 <= 1'b0;
			res_s2 <= 1'b0;
			res_s3 <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			wr_s1  <= acc && !is_drain;
			res_s1 <= acc && res;
			res_s2 <= res_s1;
			res_s3 <= res_s2;
			if (wr_s1) begin
				for (int i = 0; i < 6; i++) begin
					win_q[i] <= win_q[i+3];
				end
				win_q[6] <= up_eff;
				win_q[7] <= mid_eff;
				win_q[8] <= pix_s1;
			end
		end
	end

	// line stores: read at request, written back on the next clock
	always_ff @(posedge clk) begin
		up_rd_s1  <= upper_mem[rd_addr];
		mid_rd_s1 <= middle_mem[rd_addr];
		if (wr_s1) begin
			upper_mem[col_s1]  <= mid_eff;
			middle_mem[col_s1] <= pix_s1;
		end
	end

	// stage 1 payload, with bypass of the write still in flight
	always_ff @(posedge clk) begin
		pix_s1     <= pix_word;
		col_s1     <= rd_addr;
		sharp_s1   <= pix_emit && interior;
		fe_s1      <= fe_now;
		up_s1      <= pend_sat == wp1;
		byp_s1     <= wr_s1 && (rd_addr == col_s1);
		byp_up_s1  <= mid_eff;
		byp_mid_s1 <= pix_s1;
	end

	assign mid_eff = byp_s1 ? byp_mid_s1 : mid_rd_s1;
	assign up_eff  = byp_s1 ? byp_up_s1 : up_rd_s1;

	// laplacian
	always_comb begin
		if (wr_s1) begin
			cen_c = win_q[7];
		end else begin
			cen_c = up_s1 ? up_eff : mid_eff;
		end
		for (int i = 0; i < 3; i++) begin
			lap_c[i] = $signed({1'b0, cen_c[8*i +: 8], 2'b00})
				- $signed({3'b000, win_q[6][8*i +: 8]})
				- $signed({3'b000, win_q[8][8*i +: 8]})
				- $signed({3'b000, win_q[4][8*i +: 8]})
				- $signed({3'b000, mid_eff[8*i +: 8]});
		end
	end

	always_ff @(posedge clk) begin
		sharp_s2 <= sharp_s1;
		fe_s2    <= fe_s1;
		cen_s2   <= cen_c;
		for (int i = 0; i < 3; i++) begin
			lap_s2[i] <= lap_c[i];
		end
	end

	// gain multiply on the magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i]  = lap_s2[i][lss_pkg::LAP_W-1] ? lss_pkg::MAG_W'(-lap_s2[i])
				: lss_pkg::MAG_W'(lap_s2[i]);
			prod_c[i] = lss_pkg::PROD_W'(amount_q) * lss_pkg::PROD_W'(mag_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		sharp_s3 <= sharp_s2;
		fe_s3    <= fe_s2;
		cen_s3   <= cen_s2;
		for (int i = 0; i < 3; i++) begin
			prod_s3[i] <= prod_c[i];
			neg_s3[i]  <= lap_s2[i][lss_pkg::LAP_W-1];
		end
	end

	// divide by fifty, add and clamp
	always_comb begin
		logic [lss_pkg::QW-1:0]        qw;
		logic [lss_pkg::Q_W-1:0]       q;
		logic signed [lss_pkg::V_W-1:0] v;
		qw = '0;
		q  = '0;
		v  = '0;
		for (int i = 0; i < 3; i++) begin
			qw = lss_pkg::QW'(prod_s3[i]) * lss_pkg::QW'(lss_pkg::RECIP_50);
			q  = lss_pkg::Q_W'(qw >> lss_pkg::RECIP_SHIFT);
			v  = $signed({6'b000000, cen_s3[8*i +: 8]})
				+ (neg_s3[i] ? -$signed({2'b00, q}) : $signed({2'b00, q}));
			if (!sharp_s3) begin
				ch_out[i] = cen_s3[8*i +: 8];
			end else if (v < 0) begin
				ch_out[i] = 8'd0;
			end else if (v > 255) begin
				ch_out[i] = 8'd255;
			end else begin
				ch_out[i] = 8'(v);
			end
		end
		res_c.red       = ch_out[2];
		res_c.green     = ch_out[1];
		res_c.blue      = ch_out[0];
		res_c.alpha     = cen_s3[31:24];
		res_c.frame_end = fe_s3;
	end

	// output queue
	assign push = res_s3;
	assign pop  = pix_out.valid && pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + lss_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lss_pkg::FIFO_AW'(1);
			end
			cnt_q <= cnt_q + lss_pkg::FIFO_CW'(push) - lss_pkg::FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= res_c;
		end
	end

	assign pix_out.valid     = cnt_q != '0;
	assign pix_out.red_out   = fifo_mem[rd_ptr_q].red;
	assign pix_out.green_out = fifo_mem[rd_ptr_q].green;
	assign pix_out.blue_out  = fifo_mem[rd_ptr_q].blue;
	assign pix_out.alpha_out = fifo_mem[rd_ptr_q].alpha;
	assign pix_out.frame_end = fifo_mem[rd_ptr_q].frame_end;

endmodule

`default_nettype wire

// File: rtl/lss_checker.sv
// port-level checker of the sharpening stream unit and its bind
// depends on laplacian_sharpen_stream_unit_assert.svh and the top level
`default_nettype none

`include "laplacian_sharpen_stream_unit_assert.svh"

module lss_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [32:0] out_data
);

	logic [31:0] bal_q;
	logic        in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests taken minus results delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_q <= '0;
		end else if (in_acc && !out_acc && bal_q != '1) begin
			bal_q <= bal_q + 32'd1;
		end else if (!in_acc && out_acc && bal_q != '0) begin
			bal_q <= bal_q - 32'd1;
		end
	end

	`LSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
	`LSS_ASSERT_IMM(a_reset_empty, $rose(arst_n), !out_valid, "result present right after reset")
	`LSS_ASSERT_IMM(a_no_extra, out_acc, bal_q != '0 || in_acc, "result without a request")
	`LSS_ASSERT_IMM(a_stall_cause, !in_ready, out_valid, "input stalled with empty output")

endmodule

bind laplacian_sharpen_stream_unit lss_checker u_lss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_data  ({pix_out.red_out, pix_out.green_out, pix_out.blue_out,
		pix_out.alpha_out, pix_out.frame_end})
);

`default_nettype wire
